// ===== rtl/clipped_shape_fill_engine_assert.svh =====
// Assertion macros shared by the RTL files.
// ASSERT_AT checks a property on the rising edge of ck, disabled while rn is low.
// ASSERT_NEVER checks that an expression never holds.
`ifndef CLIPPED_SHAPE_FILL_ENGINE_ASSERT_SVH
`define CLIPPED_SHAPE_FILL_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_AT(label, ck, rn, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define ASSERT_NEVER(label, ck, rn, expr, msg) \
    `ASSERT_AT(label, ck, rn, !(expr), msg)
`else
`define ASSERT_AT(label, ck, rn, prop, msg)
`define ASSERT_NEVER(label, ck, rn, expr, msg)
`endif

`endif

// ===== rtl/csfe_pkg.sv =====
package csfe_pkg;

    localparam int OP_W    = 3;
    localparam int COORD_W = 9;
    localparam int SIZE_W  = 8;
    localparam int RAD_W   = 7;
    localparam int COLOR_W = 24;
    localparam int GLYPH_W = 16;

    // signed width of unclipped box bounds
    localparam int BOX_W = 11;

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUT    = 3'd1;
    localparam logic [OP_W-1:0] OP_RECT   = 3'd2;
    localparam logic [OP_W-1:0] OP_CIRCLE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    localparam logic [COLOR_W-1:0] WHITE_FG    = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] BLACK_BG    = 24'h000000;
    localparam logic [GLYPH_W-1:0] BLANK_GLYPH = 16'h3000;

    typedef struct packed {
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic [GLYPH_W-1:0] glyph;
    } cell_t;

    localparam cell_t BLANK_CELL = '{fg: WHITE_FG, bg: BLACK_BG, glyph: BLANK_GLYPH};

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_WIPE,
        S_SETUP,
        S_CLIP,
        S_FILL,
        S_READ,
        S_DONE
    } state_t;

endpackage

// ===== rtl/csfe_channels.sv =====
interface csfe_cmd_if;
    import csfe_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] y_pos;
    logic [SIZE_W-1:0]         rect_width;
    logic [SIZE_W-1:0]         rect_height;
    logic [RAD_W-1:0]          radius;
    logic [COLOR_W-1:0]        text_color;
    logic [COLOR_W-1:0]        back_color;
    logic [GLYPH_W-1:0]        glyph;

    modport source (
        output valid, op, x_pos, y_pos, rect_width, rect_height, radius,
               text_color, back_color, glyph,
        input  ready
    );
    modport sink (
        input  valid, op, x_pos, y_pos, rect_width, rect_height, radius,
               text_color, back_color, glyph,
        output ready
    );
endinterface

interface csfe_res_if;
    import csfe_pkg::*;

    logic               valid;
    logic               ready;
    logic               done_res;
    logic               read_valid;
    logic [COLOR_W-1:0] read_text_color;
    logic [COLOR_W-1:0] read_back_color;
    logic [GLYPH_W-1:0] read_glyph;

    modport source (
        output valid, done_res, read_valid, read_text_color, read_back_color, read_glyph,
        input  ready
    );
    modport sink (
        input  valid, done_res, read_valid, read_text_color, read_back_color, read_glyph,
        output ready
    );
endinterface

// ===== rtl/csfe_ram.sv =====
module csfe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/clipped_shape_fill_engine.sv =====
// Character-cell framebuffer with a command channel (cmd) and a result channel (res).
// Each cell holds a foreground color, a background color and a glyph code, all kept
// in one single-port-write, registered-read RAM of SCREEN_WIDTH*SCREEN_HEIGHT words.
// One cmd transaction yields exactly one res transaction, in order.
// Steps from acceptance to the result register:
//   clear       : wipe of every cell (one cell written per cycle)
//   put         : setup, clip, then write of the one cell
//   rectangle   : setup, clip, then scan of the clipped box (one cell visited per cycle)
//   circle      : setup, clip, then scan of the clipped 2r x 2r box (one cell per cycle)
//   read        : S_READ issues the RAM read, S_DONE takes the registered data
//   unknown op  : straight to the result
// The RAM write port, one cell per cycle, sets the rate of clear and fills.
// One command is in work at a time; cmd.ready is high only when the engine is idle.
// Reset starts a clearing pass over all CELLS cells (2048 by default) that puts every cell
// to white text, black background, blank glyph; cmd.ready stays low until it ends.
// The result sits in an output register. A new command is accepted while it waits;
// that command runs and then holds in its final state until res.ready frees the slot.
`include "clipped_shape_fill_engine_assert.svh"

module clipped_shape_fill_engine #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32
) (
    input  logic clk,
    input  logic rst_n,
    csfe_cmd_if.sink   cmd,
    csfe_res_if.source res
);
    import csfe_pkg::*;

    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int XW    = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int YW    = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int RR_W  = 2 * RAD_W;
    localparam int SQ_W  = 2 * SIZE_W;

    localparam logic [AW-1:0]           CELL_LAST = AW'(CELLS - 1);
    localparam logic signed [BOX_W-1:0] X_MAX     = BOX_W'(SCREEN_WIDTH - 1);
    localparam logic signed [BOX_W-1:0] Y_MAX     = BOX_W'(SCREEN_HEIGHT - 1);
    localparam logic signed [BOX_W-1:0] BOX_ZERO  = '0;
    localparam logic signed [BOX_W-1:0] BOX_ONE   = BOX_W'(1);

    function automatic logic [AW-1:0] cell_index(input logic [YW-1:0] yy,
                                                 input logic [XW-1:0] xx);
        cell_index = AW'(int'(yy) * SCREEN_WIDTH + int'(xx));
    endfunction

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;

    // latched command
    logic [OP_W-1:0]           op_reg, op_next;
    logic signed [COORD_W-1:0] px_reg, px_next;
    logic signed [COORD_W-1:0] py_reg, py_next;
    logic [SIZE_W-1:0]         w_reg, w_next;
    logic [SIZE_W-1:0]         h_reg, h_next;
    logic [RAD_W-1:0]          r_reg, r_next;
    cell_t                     cell_reg, cell_next;

    // unclipped box, then clipped scan window
    logic signed [BOX_W-1:0] bx_lo_reg, bx_lo_next;
    logic signed [BOX_W-1:0] bx_hi_reg, bx_hi_next;
    logic signed [BOX_W-1:0] by_lo_reg, by_lo_next;
    logic signed [BOX_W-1:0] by_hi_reg, by_hi_next;
    logic [RR_W-1:0]         rr_reg, rr_next;
    logic [XW-1:0]           x_lo_reg, x_lo_next;
    logic [XW-1:0]           x_hi_reg, x_hi_next;
    logic [YW-1:0]           y_hi_reg, y_hi_next;
    logic [XW-1:0]           x_reg, x_next;
    logic [YW-1:0]           y_reg, y_next;
    logic                    rd_ok_reg, rd_ok_next;

    // result slot
    logic               res_valid_reg, res_valid_next;
    logic               res_done_reg, res_done_next;
    logic               res_rv_reg, res_rv_next;
    logic [COLOR_W-1:0] res_fg_reg, res_fg_next;
    logic [COLOR_W-1:0] res_bg_reg, res_bg_next;
    logic [GLYPH_W-1:0] res_gl_reg, res_gl_next;

    // ---------------------------------------------------------------
    // RAM
    // ---------------------------------------------------------------
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    cell_t         ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    cell_t         ram_rdata;

    csfe_ram #(
        .WIDTH ($bits(cell_t)),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------
    logic cmd_fire;
    logic res_free;
    logic res_load;
    logic clr_last;
    logic scan_last;
    logic box_empty;
    logic rd_on_screen;
    logic cell_hit;
    logic scan_out_win;
    logic res_posted;

    logic signed [BOX_W-1:0] px_ext, py_ext;
    logic [SIZE_W-1:0]       ext_x_lo, ext_x_hi, ext_y_lo, ext_y_hi;
    logic signed [BOX_W-1:0] dx, dy;
    logic signed [SQ_W-1:0]  dx_w, dy_w;
    logic [SQ_W-1:0]         dx_sq, dy_sq;
    logic [SQ_W:0]           sq_sum;

    assign cmd_fire  = cmd.valid && cmd.ready;
    assign res_free  = !res_valid_reg || res.ready;
    assign clr_last  = (clr_reg == CELL_LAST);
    assign scan_last = (x_reg == x_hi_reg) && (y_reg == y_hi_reg);

    assign px_ext = $signed({{(BOX_W - COORD_W){px_reg[COORD_W-1]}}, px_reg});
    assign py_ext = $signed({{(BOX_W - COORD_W){py_reg[COORD_W-1]}}, py_reg});

    // extents left/right of the anchor; hi side is exclusive
    always_comb
    begin
        case (op_reg)
            OP_RECT:
            begin
                ext_x_lo = w_reg >> 1;
                ext_x_hi = w_reg - (w_reg >> 1);
                ext_y_lo = h_reg >> 1;
                ext_y_hi = h_reg - (h_reg >> 1);
            end
            OP_CIRCLE:
            begin
                ext_x_lo = {1'b0, r_reg};
                ext_x_hi = {1'b0, r_reg};
                ext_y_lo = {1'b0, r_reg};
                ext_y_hi = {1'b0, r_reg};
            end
            default:
            begin
                ext_x_lo = '0;
                ext_x_hi = SIZE_W'(1);
                ext_y_lo = '0;
                ext_y_hi = SIZE_W'(1);
            end
        endcase
    end

    // zero size gives hi < lo
    assign box_empty = (bx_hi_reg < bx_lo_reg) || (by_hi_reg < by_lo_reg)
                    || (bx_hi_reg < BOX_ZERO) || (by_hi_reg < BOX_ZERO)
                    || (bx_lo_reg > X_MAX) || (by_lo_reg > Y_MAX);

    assign rd_on_screen = (px_ext >= BOX_ZERO) && (px_ext <= X_MAX)
                       && (py_ext >= BOX_ZERO) && (py_ext <= Y_MAX);

    // circle membership of the current scan cell
    assign dx     = $signed({{(BOX_W - XW){1'b0}}, x_reg}) - px_ext;
    assign dy     = $signed({{(BOX_W - YW){1'b0}}, y_reg}) - py_ext;
    assign dx_w   = SQ_W'($signed(dx[SIZE_W-1:0]));
    assign dy_w   = SQ_W'($signed(dy[SIZE_W-1:0]));
    assign dx_sq  = SQ_W'(dx_w * dx_w);
    assign dy_sq  = SQ_W'(dy_w * dy_w);
    assign sq_sum = {1'b0, dx_sq} + {1'b0, dy_sq};
    assign cell_hit = (op_reg != OP_CIRCLE) || (sq_sum <= (SQ_W + 1)'(rr_reg));

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    case (cmd.op)
                        OP_CLEAR:                    state_next = S_WIPE;
                        OP_PUT, OP_RECT, OP_CIRCLE:  state_next = S_SETUP;
                        OP_READ:                     state_next = S_READ;
                        default:                     state_next = S_DONE;
                    endcase
                end
            end
            S_WIPE:
            begin
                if (clr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_SETUP: state_next = S_CLIP;
            S_CLIP:  state_next = box_empty ? S_DONE : S_FILL;
            S_FILL:
            begin
                if (scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_READ: state_next = S_DONE;
            S_DONE:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    // ---------------------------------------------------------------
    // Outputs of the sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        cmd.ready = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = BLANK_CELL;
        ram_re    = 1'b0;
        ram_raddr = cell_index(py_reg[YW-1:0], px_reg[XW-1:0]);
        res_load  = 1'b0;
        case (state_reg)
            S_INIT, S_WIPE:
            begin
                ram_we = 1'b1;
            end
            S_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            S_FILL:
            begin
                ram_we    = cell_hit;
                ram_waddr = cell_index(y_reg, x_reg);
                ram_wdata = cell_reg;
            end
            S_READ:
            begin
                ram_re = rd_on_screen;
            end
            S_DONE:
            begin
                res_load = res_free;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath next values
    // ---------------------------------------------------------------
    always_comb
    begin
        clr_next   = clr_reg;
        op_next    = op_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        r_next     = r_reg;
        cell_next  = cell_reg;
        bx_lo_next = bx_lo_reg;
        bx_hi_next = bx_hi_reg;
        by_lo_next = by_lo_reg;
        by_hi_next = by_hi_reg;
        rr_next    = rr_reg;
        x_lo_next  = x_lo_reg;
        x_hi_next  = x_hi_reg;
        y_hi_next  = y_hi_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        rd_ok_next = rd_ok_reg;

        if ((state_reg == S_INIT) || (state_reg == S_WIPE))
        begin
            clr_next = clr_last ? '0 : clr_reg + AW'(1);
        end

        if (cmd_fire)
        begin
            op_next   = cmd.op;
            px_next   = cmd.x_pos;
            py_next   = cmd.y_pos;
            w_next    = cmd.rect_width;
            h_next    = cmd.rect_height;
            r_next    = cmd.radius;
            cell_next = '{fg: cmd.text_color, bg: cmd.back_color, glyph: cmd.glyph};
        end

        if (state_reg == S_SETUP)
        begin
            bx_lo_next = px_ext - $signed({3'b000, ext_x_lo});
            bx_hi_next = px_ext + $signed({3'b000, ext_x_hi}) - BOX_ONE;
            by_lo_next = py_ext - $signed({3'b000, ext_y_lo});
            by_hi_next = py_ext + $signed({3'b000, ext_y_hi}) - BOX_ONE;
            rr_next    = {{RAD_W{1'b0}}, r_reg} * {{RAD_W{1'b0}}, r_reg};
        end

        if (state_reg == S_CLIP)
        begin
            x_lo_next = (bx_lo_reg < BOX_ZERO) ? '0 : bx_lo_reg[XW-1:0];
            x_hi_next = (bx_hi_reg > X_MAX) ? X_MAX[XW-1:0] : bx_hi_reg[XW-1:0];
            y_hi_next = (by_hi_reg > Y_MAX) ? Y_MAX[YW-1:0] : by_hi_reg[YW-1:0];
            x_next    = x_lo_next;
            y_next    = (by_lo_reg < BOX_ZERO) ? '0 : by_lo_reg[YW-1:0];
        end

        if (state_reg == S_FILL)
        begin
            if (x_reg == x_hi_reg)
            begin
                x_next = x_lo_reg;
                if (y_reg != y_hi_reg)
                begin
                    y_next = y_reg + YW'(1);
                end
            end
            else
            begin
                x_next = x_reg + XW'(1);
            end
        end

        if (state_reg == S_READ)
        begin
            rd_ok_next = rd_on_screen;
        end
    end

    // result slot
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_done_next  = res_done_reg;
        res_rv_next    = res_rv_reg;
        res_fg_next    = res_fg_reg;
        res_bg_next    = res_bg_reg;
        res_gl_next    = res_gl_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
            res_done_next  = 1'b1;
            if ((op_reg == OP_READ) && rd_ok_reg)
            begin
                res_rv_next = 1'b1;
                res_fg_next = ram_rdata.fg;
                res_bg_next = ram_rdata.bg;
                res_gl_next = ram_rdata.glyph;
            end
            else
            begin
                res_rv_next = 1'b0;
                res_fg_next = '0;
                res_bg_next = '0;
                res_gl_next = '0;
            end
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Register update
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        r_reg      <= r_next;
        cell_reg   <= cell_next;
        bx_lo_reg  <= bx_lo_next;
        bx_hi_reg  <= bx_hi_next;
        by_lo_reg  <= by_lo_next;
        by_hi_reg  <= by_hi_next;
        rr_reg     <= rr_next;
        x_lo_reg   <= x_lo_next;
        x_hi_reg   <= x_hi_next;
        y_hi_reg   <= y_hi_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        rd_ok_reg  <= rd_ok_next;
        res_done_reg <= res_done_next;
        res_rv_reg   <= res_rv_next;
        res_fg_reg   <= res_fg_next;
        res_bg_reg   <= res_bg_next;
        res_gl_reg   <= res_gl_next;
    end

    assign res.valid           = res_valid_reg;
    assign res.done_res        = res_done_reg;
    assign res.read_valid      = res_rv_reg;
    assign res.read_text_color = res_fg_reg;
    assign res.read_back_color = res_bg_reg;
    assign res.read_glyph      = res_gl_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    assign scan_out_win = (state_reg == S_FILL) && ((x_reg > x_hi_reg) || (y_reg > y_hi_reg));
    assign res_posted   = res.valid && (state_reg == S_IDLE);

    `ASSERT_AT(a_accept_leaves_idle, clk, rst_n, cmd_fire |=> (state_reg != S_IDLE), "no start")
    `ASSERT_NEVER(a_scan_in_window, clk, rst_n, scan_out_win, "scan outside window")
    `ASSERT_NEVER(a_write_in_range, clk, rst_n, ram_we && (ram_waddr > CELL_LAST), "bad waddr")
    `ASSERT_AT(a_load_shows_result, clk, rst_n, res_load |=> res_posted, "result not posted")

endmodule
